>>> rtl/salc_pkg.sv
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types, widths and register codes of the set-associative cache unit.
// ----------------------------------------------------------------------------
package salc_pkg;

	localparam int ADDR_W   = 32;
	localparam int SET_CNT  = 1024;
	localparam int SET_W    = 10;
	localparam int WAY_CNT  = 8;
	localparam int WAY_W    = 3;
	localparam int WAYS_W   = 4;
	localparam int STAMP_W  = 32;
	localparam int OFS_W    = 3;
	localparam int IDX_W    = 4;
	localparam int SHIFT_W  = 5;
	localparam int PADDR_W  = 4;
	localparam int PDATA_W  = 32;

	localparam logic [1:0] REG_OFFSET = 2'd0;
	localparam logic [1:0] REG_INDEX  = 2'd1;
	localparam logic [1:0] REG_WAYS   = 2'd2;

	localparam logic [OFS_W-1:0]  OFS_RST  = 3'd5;
	localparam logic [IDX_W-1:0]  IDX_RST  = 4'd6;
	localparam logic [WAYS_W-1:0] WAYS_RST = 4'd4;

	typedef struct packed {
		logic [OFS_W-1:0]  ofs_w;
		logic [IDX_W-1:0]  idx_w;
		logic [WAYS_W-1:0] ways;
	} cfg_t;

	typedef struct packed {
		logic               valid;
		logic               dirty;
		logic [ADDR_W-1:0]  tag;
		logic [ADDR_W-1:0]  fill;
		logic [STAMP_W-1:0] stamp;
	} line_t;

	typedef struct packed {
		line_t [WAY_CNT-1:0] line;
		logic [STAMP_W-1:0]  ctr;
	} row_t;

	typedef struct packed {
		logic               en;
		logic [STAMP_W-1:0] stamp;
		logic [WAY_W-1:0]   way;
	} node_t;

	typedef struct packed {
		logic             clr_we;
		logic [SET_W-1:0] clr_set;
		logic             accept;
		logic             commit;
	} cmd_t;

	typedef struct packed {
		logic rsp_busy;
	} sts_t;

	// Left operand wins ties, so the lowest way is kept on equal stamps.
	function automatic node_t lru_pick(input node_t a, input node_t b);
		node_t r;
		if (!a.en) begin
			r = b;
		end else if (b.en && (b.stamp < a.stamp)) begin
			r = b;
		end else begin
			r = a;
		end
		return r;
	endfunction

endpackage

>>> rtl/salc_if.sv
// ----------------------------------------------------------------------------
// salc_if
// Request and response channels of the set-associative cache unit.
// ----------------------------------------------------------------------------
interface salc_req_if;
	logic                        valid;
	logic                        ready;
	logic [salc_pkg::ADDR_W-1:0] address;
	logic                        is_write;

	modport source(output valid, output address, output is_write, input ready);
	modport sink(input valid, input address, input is_write, output ready);
endinterface

interface salc_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        hit;
	logic [salc_pkg::SET_W-1:0]  set_index;
	logic [salc_pkg::WAY_W-1:0]  way_used;
	logic                        writeback_valid;
	logic [salc_pkg::ADDR_W-1:0] writeback_address;
	logic                        fetch_valid;
	logic [salc_pkg::ADDR_W-1:0] fetch_address;

	modport source(output valid, output hit, output set_index, output way_used,
		output writeback_valid, output writeback_address, output fetch_valid,
		output fetch_address, input ready);
	modport sink(input valid, input hit, input set_index, input way_used,
		input writeback_valid, input writeback_address, input fetch_valid,
		input fetch_address, output ready);
endinterface

>>> rtl/salc_cfg.sv
// ----------------------------------------------------------------------------
// salc_cfg
// APB register file: offset width, index width and ways in use, with the
// effective (saturated) values for the datapath.
// ----------------------------------------------------------------------------
module salc_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [salc_pkg::PADDR_W-1:0]  paddr,
	input  logic [salc_pkg::PDATA_W-1:0]  pwdata,
	output logic [salc_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output salc_pkg::cfg_t                cfg
);

	logic [salc_pkg::OFS_W-1:0]  ofs_q;
	logic [salc_pkg::IDX_W-1:0]  idx_q;
	logic [salc_pkg::WAYS_W-1:0] ways_q;
	logic                        wr_en;
	logic [1:0]                  reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ofs_q  <= salc_pkg::OFS_RST;
			idx_q  <= salc_pkg::IDX_RST;
			ways_q <= salc_pkg::WAYS_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				salc_pkg::REG_OFFSET: ofs_q  <= pwdata[salc_pkg::OFS_W-1:0];
				salc_pkg::REG_INDEX:  idx_q  <= pwdata[salc_pkg::IDX_W-1:0];
				salc_pkg::REG_WAYS:   ways_q <= pwdata[salc_pkg::WAYS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			salc_pkg::REG_OFFSET: prdata = salc_pkg::PDATA_W'(ofs_q);
			salc_pkg::REG_INDEX:  prdata = salc_pkg::PDATA_W'(idx_q);
			salc_pkg::REG_WAYS:   prdata = salc_pkg::PDATA_W'(ways_q);
			default:              prdata = '0;
		endcase
	end

	always_comb begin
		cfg.ofs_w = ofs_q;
		if (idx_q > salc_pkg::IDX_W'(salc_pkg::SET_W)) begin
			cfg.idx_w = salc_pkg::IDX_W'(salc_pkg::SET_W);
		end else begin
			cfg.idx_w = idx_q;
		end
		if (ways_q == '0) begin
			cfg.ways = salc_pkg::WAYS_W'(1);
		end else if (ways_q > salc_pkg::WAYS_W'(salc_pkg::WAY_CNT)) begin
			cfg.ways = salc_pkg::WAYS_W'(salc_pkg::WAY_CNT);
		end else begin
			cfg.ways = ways_q;
		end
	end

endmodule

>>> rtl/salc_ctrl.sv
// ----------------------------------------------------------------------------
// salc_ctrl
// Controller: clearing sweep after reset, then accept, look up and commit.
// ----------------------------------------------------------------------------
module salc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  salc_pkg::sts_t sts,
	output salc_pkg::cmd_t cmd
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_LOOK  = 2'd2;

	logic [1:0]                 state_q;
	logic [salc_pkg::SET_W-1:0] clr_q;

	assign req_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd.clr_we  = (state_q == ST_CLEAR);
		cmd.clr_set = clr_q;
		cmd.accept  = req_ready && req_valid;
		cmd.commit  = (state_q == ST_LOOK) && !sts.rsp_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == salc_pkg::SET_W'(salc_pkg::SET_CNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd.accept) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (cmd.commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/salc_dp.sv
// ----------------------------------------------------------------------------
// salc_dp
// Datapath: address split, set memory, tag match, LRU victim choice, line
// update and the response register.
// ----------------------------------------------------------------------------
module salc_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  salc_pkg::cfg_t                cfg,
	input  salc_pkg::cmd_t                cmd,
	output salc_pkg::sts_t                sts,
	input  logic [salc_pkg::ADDR_W-1:0]   in_address,
	input  logic                          in_is_write,
	salc_rsp_if.source                    rsp
);

	salc_pkg::row_t mem [salc_pkg::SET_CNT];

	salc_pkg::row_t               row_q;
	salc_pkg::row_t               new_row;
	salc_pkg::row_t               wr_row;
	logic [salc_pkg::ADDR_W-1:0]  addr_q;
	logic                         wr_q;
	logic [salc_pkg::SET_W-1:0]   set_q;
	logic [salc_pkg::ADDR_W-1:0]  tag_q;

	logic [salc_pkg::SET_W:0]     set_mask_wide;
	logic [salc_pkg::ADDR_W-1:0]  ofs_shifted;
	logic [salc_pkg::SHIFT_W-1:0] tag_shift;
	logic [salc_pkg::SET_W-1:0]   in_set;
	logic [salc_pkg::ADDR_W-1:0]  in_tag;
	logic [salc_pkg::SET_W-1:0]   wr_set;

	logic                         hit;
	logic [salc_pkg::WAY_W-1:0]   hit_way;
	logic                         inv_found;
	logic [salc_pkg::WAY_W-1:0]   inv_way;
	logic [salc_pkg::WAY_W-1:0]   victim;
	logic                         wb;
	logic [salc_pkg::ADDR_W-1:0]  wb_addr;
	salc_pkg::node_t              l0 [salc_pkg::WAY_CNT];
	salc_pkg::node_t              l1 [4];
	salc_pkg::node_t              l2 [2];
	salc_pkg::node_t              l3;

	logic                         rsp_valid_q;
	logic                         hit_q;
	logic [salc_pkg::SET_W-1:0]   set_index_q;
	logic [salc_pkg::WAY_W-1:0]   way_used_q;
	logic                         wb_valid_q;
	logic [salc_pkg::ADDR_W-1:0]  wb_addr_q;
	logic                         fetch_valid_q;
	logic [salc_pkg::ADDR_W-1:0]  fetch_addr_q;

	// Address split
	always_comb begin
		set_mask_wide = ((salc_pkg::SET_W + 1)'(1) << cfg.idx_w) - 1'b1;
		ofs_shifted   = in_address >> cfg.ofs_w;
		in_set        = ofs_shifted[salc_pkg::SET_W-1:0] &
			set_mask_wide[salc_pkg::SET_W-1:0];
		tag_shift     = salc_pkg::SHIFT_W'(cfg.ofs_w) + salc_pkg::SHIFT_W'(cfg.idx_w);
		in_tag        = in_address >> tag_shift;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			addr_q <= in_address;
			wr_q   <= in_is_write;
			set_q  <= in_set;
			tag_q  <= in_tag;
			row_q  <= mem[in_set];
		end
	end

	always_comb begin
		wr_set = cmd.clr_we ? cmd.clr_set : set_q;
		wr_row = cmd.clr_we ? '0 : new_row;
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_we || cmd.commit) begin
			mem[wr_set] <= wr_row;
		end
	end

	// Tag match and first free way
	always_comb begin
		hit       = 1'b0;
		hit_way   = '0;
		inv_found = 1'b0;
		inv_way   = '0;
		for (int w = 0; w < salc_pkg::WAY_CNT; w++) begin
			if (salc_pkg::WAYS_W'(w) < cfg.ways) begin
				if (row_q.line[w].valid) begin
					if (!hit && (row_q.line[w].tag == tag_q)) begin
						hit     = 1'b1;
						hit_way = salc_pkg::WAY_W'(w);
					end
				end else if (!inv_found) begin
					inv_found = 1'b1;
					inv_way   = salc_pkg::WAY_W'(w);
				end
			end
		end
	end

	// LRU tree over the ways in use
	always_comb begin
		for (int w = 0; w < salc_pkg::WAY_CNT; w++) begin
			l0[w].en    = salc_pkg::WAYS_W'(w) < cfg.ways;
			l0[w].stamp = row_q.line[w].stamp;
			l0[w].way   = salc_pkg::WAY_W'(w);
		end
		for (int i = 0; i < 4; i++) begin
			l1[i] = salc_pkg::lru_pick(l0[2*i], l0[2*i+1]);
		end
		for (int i = 0; i < 2; i++) begin
			l2[i] = salc_pkg::lru_pick(l1[2*i], l1[2*i+1]);
		end
		l3 = salc_pkg::lru_pick(l2[0], l2[1]);
	end

	// Line update
	always_comb begin
		priority if (hit) begin
			victim = hit_way;
		end else if (inv_found) begin
			victim = inv_way;
		end else begin
			victim = l3.way;
		end
		wb      = !hit && !inv_found && row_q.line[l3.way].dirty;
		wb_addr = wb ? row_q.line[l3.way].fill : '0;

		new_row     = row_q;
		new_row.ctr = row_q.ctr + 1'b1;
		new_row.line[victim].stamp = row_q.ctr;
		if (hit) begin
			new_row.line[victim].dirty = row_q.line[victim].dirty | wr_q;
		end else begin
			new_row.line[victim].valid = 1'b1;
			new_row.line[victim].dirty = wr_q;
			new_row.line[victim].tag   = tag_q;
			new_row.line[victim].fill  = addr_q;
		end
	end

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			hit_q         <= hit;
			set_index_q   <= set_q;
			way_used_q    <= victim;
			wb_valid_q    <= wb;
			wb_addr_q     <= wb_addr;
			fetch_valid_q <= !hit;
			fetch_addr_q  <= hit ? '0 : addr_q;
		end
	end

	assign sts.rsp_busy          = rsp_valid_q && !rsp.ready;
	assign rsp.valid             = rsp_valid_q;
	assign rsp.hit               = hit_q;
	assign rsp.set_index         = set_index_q;
	assign rsp.way_used          = way_used_q;
	assign rsp.writeback_valid   = wb_valid_q;
	assign rsp.writeback_address = wb_addr_q;
	assign rsp.fetch_valid       = fetch_valid_q;
	assign rsp.fetch_address     = fetch_addr_q;

endmodule

>>> rtl/set_assoc_lru_writeback_cache_unit.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_writeback_cache_unit
// Tag and state controller of a set-associative, write-back, write-allocate
// cache with LRU replacement. After reset the unit sweeps its set memory, one
// set per cycle over all 1024 sets, with req.ready low; APB writes are taken
// throughout. Each access then reads the set's row (tags, stamps, valid and
// dirty bits of all ways, and its use counter) from the single-port set
// memory into a register when it is taken, then matches all ways in parallel,
// chooses a victim and writes the row back when the output register is free.
// One access is in flight at a time; the next is taken while the previous
// response still waits in the output register. Change the configuration only
// while idle; stored lines are kept and looked up with the new address split.
// ----------------------------------------------------------------------------
module set_assoc_lru_writeback_cache_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [salc_pkg::PADDR_W-1:0]  paddr,
	input  logic [salc_pkg::PDATA_W-1:0]  pwdata,
	output logic [salc_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	salc_req_if.sink                      req,
	salc_rsp_if.source                    rsp
);

	salc_pkg::cfg_t cfg;
	salc_pkg::cmd_t cmd;
	salc_pkg::sts_t sts;

	salc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	salc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	salc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.sts         (sts),
		.in_address  (req.address),
		.in_is_write (req.is_write),
		.rsp         (rsp)
	);

endmodule

>>> rtl/salc_chk.sv
// ----------------------------------------------------------------------------
// salc_chk
// Port-level checks of the cache unit, bound to the top level.
// ----------------------------------------------------------------------------
module salc_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic                        hit,
	input logic [salc_pkg::SET_W-1:0]  set_index,
	input logic                        writeback_valid,
	input logic [salc_pkg::ADDR_W-1:0] writeback_address,
	input logic                        fetch_valid
);

	a_hit_no_traffic: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && hit |-> !fetch_valid && !writeback_valid)
		else $error("hit with fetch or writeback");

	a_miss_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !hit |-> fetch_valid)
		else $error("miss without fetch");

	a_wb_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !writeback_valid |-> writeback_address == '0)
		else $error("writeback address without writeback");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second access taken while one is in flight");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(set_index))
		else $error("stalled response changed");

endmodule

bind set_assoc_lru_writeback_cache_unit salc_chk u_salc_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.hit               (rsp.hit),
	.set_index         (rsp.set_index),
	.writeback_valid   (rsp.writeback_valid),
	.writeback_address (rsp.writeback_address),
	.fetch_valid       (rsp.fetch_valid)
);
